// ----- rtl/arp_cache_responder_assert.svh -----
// Assertion macros for the ARP cache responder.
// Used by the top level; expects clk and arst_n in the including scope.
`ifndef ARP_CACHE_RESPONDER_ASSERT_SVH
`define ARP_CACHE_RESPONDER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ARPC_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ARPC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/arpc_pkg.sv -----
// Shared types and constants for the ARP cache responder.
// No dependencies; every other file but the assert header imports it.
`default_nettype none

package arpc_pkg;

	localparam int CACHE_ENTRIES = 16;
	localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;

	localparam int IP_W  = 32;
	localparam int MAC_W = 48;
	localparam int OP_W  = 16;

	// Command queue between front and back; depth must be a power of two.
	localparam int Q_DEPTH = 2;
	localparam int QPTR_W  = $clog2(Q_DEPTH);
	localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

	// Register port.
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 64;
	localparam logic [PADDR_W-1:0] ADDR_OWN_IP  = 4'h0;
	localparam logic [PADDR_W-1:0] ADDR_OWN_MAC = 4'h8;

	localparam logic [IP_W-1:0]  OWN_IP_RESET  = 32'h0F02_000A;
	localparam logic [MAC_W-1:0] OWN_MAC_RESET = '0;

	localparam logic      CMD_LOOKUP = 1'b0;
	localparam logic      CMD_ARP    = 1'b1;
	localparam logic [OP_W-1:0] ARP_OP_REQUEST = 16'd1;

	typedef struct packed {
		logic             command;
		logic [IP_W-1:0]  query_ip;
		logic             frame_too_short;
		logic [OP_W-1:0]  arp_opcode;
		logic [IP_W-1:0]  sender_ip;
		logic [MAC_W-1:0] sender_mac;
		logic [IP_W-1:0]  tgt_ip;
	} req_t;

	typedef struct packed {
		logic             hit;
		logic [MAC_W-1:0] found_mac;
		logic             send_reply;
		logic [MAC_W-1:0] reply_dest_mac;
		logic [IP_W-1:0]  reply_target_ip;
	} rsp_t;

	// Classified command as it travels through the queue.
	typedef struct packed {
		logic             is_lookup;
		logic             learn;
		logic             reply;
		logic [IP_W-1:0]  ip;
		logic [MAC_W-1:0] mac;
	} cmd_t;

	typedef struct packed {
		logic [QCNT_W-1:0] count;
	} q_stat_t;

	typedef struct packed {
		logic busy;
	} back_stat_t;

	// Index of the lowest set bit; zero when no bit is set.
	function automatic logic [IDX_W-1:0] lowest_index(input logic [CACHE_ENTRIES-1:0] v);
		logic [CACHE_ENTRIES-1:0] onehot;
		logic [IDX_W-1:0]         idx;
		onehot = v & (~v + 1'b1);
		idx = '0;
		for (int i = 0; i < CACHE_ENTRIES; i++) begin
			if (onehot[i]) begin
				idx = idx | IDX_W'(i);
			end
		end
		return idx;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/arpc_ifs.sv -----
// Valid/ready channel interfaces for request and result words.
// Depends on arpc_pkg for the payload types.
`default_nettype none

interface arpc_req_if;
	import arpc_pkg::*;
	logic valid;
	logic ready;
	req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface arpc_rsp_if;
	import arpc_pkg::*;
	logic valid;
	logic ready;
	rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/arp_cache_responder.sv -----
// Top level of the ARP cache responder.
// Depends on arpc_pkg, arpc_ifs, arpc_front, arpc_cmdq, arpc_back and the assert header.
//
// Usage: request words enter on the req channel and result words leave on the rsp
// channel, both valid/ready; a word moves on a clock edge where valid and ready are
// high. Each request word yields exactly one result word, in order. A lookup word
// (command 0) returns hit and the cached MAC; an ARP word (command 1) learns the
// sender binding and flags a reply when it is a request for own_ip.
// own_ip sits at byte address 0 and own_mac at 8 on the register port; write them
// only while no word is in flight.
// Each word is classified and queued on the edge it is accepted, then taken by the
// back end from the head of the queue, matched against all sixteen entries in its
// match step and written back with its result registered in its write-back step.
// The back end works on one word at a time, taking the next only as it finishes the
// write-back step of the last, so that a lookup always sees the binding learned
// just before it.
// Reset clears the cache valid bits at once and restores own_ip to 0x0F02000A.
// When rsp stalls, the result register holds its word; the back end waits in its
// write-back step and the two-word command queue keeps accepting until full.

`default_nettype none
`include "arp_cache_responder_assert.svh"

module arp_cache_responder (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [arpc_pkg::PADDR_W-1:0] paddr,
	input  wire logic [arpc_pkg::PDATA_W-1:0] pwdata,
	output      logic [arpc_pkg::PDATA_W-1:0] prdata,
	output      logic                         pready,
	arpc_req_if.sink                          req,
	arpc_rsp_if.source                        rsp
);
	import arpc_pkg::*;

	// Front end to queue.
	logic       push;
	cmd_t       push_cmd;
	q_stat_t    q_stat;

	// Queue to back end.
	logic       pop;
	logic       head_valid;
	cmd_t       head_cmd;
	back_stat_t back_stat;

	// The register port never inserts wait states.
	assign pready = 1'b1;

	arpc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.req      (req),
		.q_stat   (q_stat),
		.push     (push),
		.push_cmd (push_cmd)
	);

	arpc_cmdq u_cmdq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.pop        (pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.q_stat     (q_stat)
	);

	arpc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop),
		.rsp        (rsp),
		.back_stat  (back_stat)
	);

	// The front end must never push into a full queue, nor the back end pop an empty one.
	`ARPC_ASSERT_SAME(a_no_overflow, push, q_stat.count != QCNT_W'(Q_DEPTH), "queue overflow")
	`ARPC_ASSERT_SAME(a_no_underflow, pop, q_stat.count != '0, "queue underflow")
	// A popped command keeps the back end busy in the following cycle.
	`ARPC_ASSERT_NEXT(a_pop_busy, pop, back_stat.busy, "back end idle after pop")
	// A new result word only comes out of a busy back end.
	`ARPC_ASSERT_SAME(a_result_source, $rose(rsp.valid), $past(back_stat.busy), "stray result")

endmodule

`default_nettype wire

// ----- rtl/arpc_front.sv -----
// Front end: register port, request acceptance and classification.
// Depends on arpc_pkg and arpc_ifs.
`default_nettype none

module arpc_front (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [arpc_pkg::PADDR_W-1:0] paddr,
	input  wire logic [arpc_pkg::PDATA_W-1:0] pwdata,
	output      logic [arpc_pkg::PDATA_W-1:0] prdata,
	arpc_req_if.sink                         req,
	input  wire arpc_pkg::q_stat_t           q_stat,
	output      logic                        push,
	output      arpc_pkg::cmd_t              push_cmd
);
	import arpc_pkg::*;

	logic [IP_W-1:0]  own_ip_q;
	logic [MAC_W-1:0] own_mac_q;
	logic             wr_en;
	logic             is_arp;
	logic             usable;

	assign wr_en = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_ip_q  <= OWN_IP_RESET;
			own_mac_q <= OWN_MAC_RESET;
		end else if (wr_en) begin
			if (paddr == ADDR_OWN_IP) begin
				own_ip_q <= pwdata[IP_W-1:0];
			end else if (paddr == ADDR_OWN_MAC) begin
				own_mac_q <= pwdata[MAC_W-1:0];
			end
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr == ADDR_OWN_IP) begin
			prdata = PDATA_W'(own_ip_q);
		end else if (paddr == ADDR_OWN_MAC) begin
			prdata = PDATA_W'(own_mac_q);
		end
	end

	assign req.ready = (q_stat.count != QCNT_W'(Q_DEPTH));
	assign push      = req.valid && req.ready;

	// A short frame is dropped entirely but still yields an all-zero result.
	assign is_arp = (req.data.command == CMD_ARP);
	assign usable = is_arp && !req.data.frame_too_short;

	always_comb begin
		push_cmd.is_lookup = !is_arp;
		push_cmd.learn     = usable && (req.data.sender_ip != '0);
		push_cmd.reply     = usable && (req.data.arp_opcode == ARP_OP_REQUEST)
			&& (req.data.tgt_ip == own_ip_q);
		push_cmd.ip        = is_arp ? req.data.sender_ip : req.data.query_ip;
		push_cmd.mac       = req.data.sender_mac;
	end

endmodule

`default_nettype wire

// ----- rtl/arpc_cmdq.sv -----
// Small command queue between the front and back ends.
// Depends on arpc_pkg.
`default_nettype none

module arpc_cmdq (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire arpc_pkg::cmd_t    push_cmd,
	input  wire logic              pop,
	output      logic              head_valid,
	output      arpc_pkg::cmd_t    head_cmd,
	output      arpc_pkg::q_stat_t q_stat
);
	import arpc_pkg::*;

	cmd_t              mem_q [Q_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign head_valid   = (count_q != '0);
	assign head_cmd     = mem_q[rd_ptr_q];
	assign q_stat.count = count_q;

endmodule

`default_nettype wire

// ----- rtl/arpc_back.sv -----
// Back end: cache storage, match, learning and the result register.
// Depends on arpc_pkg and arpc_ifs.
`default_nettype none

module arpc_back (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 head_valid,
	input  wire arpc_pkg::cmd_t       head_cmd,
	output      logic                 pop,
	arpc_rsp_if.source                rsp,
	output      arpc_pkg::back_stat_t back_stat
);
	import arpc_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_MATCH = 3'b010,
		S_WRITE = 3'b100
	} state_t;

	state_t                   state_q;
	cmd_t                     cmd_q;
	logic [CACHE_ENTRIES-1:0] entry_valid_q;
	logic [IP_W-1:0]          entry_ip_q  [CACHE_ENTRIES];
	logic [MAC_W-1:0]         entry_mac_q [CACHE_ENTRIES];
	logic                     hit_q;
	logic [IDX_W-1:0]         slot_q;
	logic [MAC_W-1:0]         rd_mac_q;
	logic                     out_valid_q;
	rsp_t                     out_q;

	logic [CACHE_ENTRIES-1:0] match_vec;
	logic                     any_match;
	logic [IDX_W-1:0]         match_idx;
	logic [IDX_W-1:0]         free_idx;
	logic [IDX_W-1:0]         slot;
	logic                     out_free;
	logic                     finish;
	rsp_t                     result;

	always_comb begin
		for (int i = 0; i < CACHE_ENTRIES; i++) begin
			match_vec[i] = entry_valid_q[i] && (entry_ip_q[i] == cmd_q.ip);
		end
	end

	assign any_match = |match_vec;
	assign match_idx = lowest_index(match_vec);
	assign free_idx  = lowest_index(~entry_valid_q);

	// Update in place, else first free slot, else slot zero.
	always_comb begin
		if (any_match) begin
			slot = match_idx;
		end else if (!(&entry_valid_q)) begin
			slot = free_idx;
		end else begin
			slot = '0;
		end
	end

	assign out_free = !out_valid_q || rsp.ready;
	assign finish   = (state_q == S_WRITE) && out_free;
	assign pop      = head_valid && ((state_q == S_IDLE) || finish);

	always_comb begin
		result = '0;
		if (cmd_q.is_lookup) begin
			result.hit       = hit_q;
			result.found_mac = hit_q ? rd_mac_q : '0;
		end else if (cmd_q.reply) begin
			result.send_reply      = 1'b1;
			result.reply_dest_mac  = cmd_q.mac;
			result.reply_target_ip = cmd_q.ip;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			entry_valid_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (pop) begin
						state_q <= S_MATCH;
					end
				end
				S_MATCH: begin
					state_q <= S_WRITE;
				end
				S_WRITE: begin
					if (finish) begin
						if (cmd_q.learn) begin
							entry_valid_q[slot_q] <= 1'b1;
						end
						state_q <= pop ? S_MATCH : S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= head_cmd;
		end
		if (state_q == S_MATCH) begin
			hit_q    <= any_match;
			slot_q   <= slot;
			rd_mac_q <= entry_mac_q[match_idx];
		end
		if (finish && cmd_q.learn) begin
			entry_ip_q[slot_q]  <= cmd_q.ip;
			entry_mac_q[slot_q] <= cmd_q.mac;
		end
		if (finish) begin
			out_q <= result;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.data       = out_q;
	assign back_stat.busy = (state_q != S_IDLE);

endmodule

`default_nettype wire
